FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while rst is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/mscont_pkg.sv
package mscont_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int DIM_W    = 11;
   localparam int HALF_W   = 8;
   localparam int COLOR_W  = 24;
   localparam int SEG_W    = 20;

   // counters that can hold the dimension itself, and cell indexes
   localparam int W_W  = $clog2(MAX_WIDTH + 1);
   localparam int H_W  = $clog2(MAX_HEIGHT + 1);
   localparam int XI_W = $clog2(MAX_WIDTH);
   localparam int YI_W = $clog2(MAX_HEIGHT);

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic signed [SAMPLE_W-1:0] ISO_RESET   = '0;
   localparam logic [DIM_W-1:0]           GRID_RESET  = DIM_W'(1024);
   localparam logic [HALF_W-1:0]          HALF_RESET  = HALF_W'(8);
   localparam logic [COLOR_W-1:0]         COLOR_RESET = '1;

   typedef enum logic [2:0] {
      REG_ISO_LEVEL   = 3'd0,
      REG_GRID_WIDTH  = 3'd1,
      REG_GRID_HEIGHT = 3'd2,
      REG_HALF_WIDTH  = 3'd3,
      REG_HALF_HEIGHT = 3'd4,
      REG_LINE_COLOR  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] iso_level;
      logic [DIM_W-1:0]           grid_width;
      logic [DIM_W-1:0]           grid_height;
      logic [HALF_W-1:0]          half_cell_width;
      logic [HALF_W-1:0]          half_cell_height;
      logic [COLOR_W-1:0]         line_color;
   } cfg_type;

   // one classified cell waiting for segment generation
   typedef struct packed {
      logic [3:0]      corner;
      logic [XI_W-1:0] x;
      logic [YI_W-1:0] y;
   } seg_item_type;

   function automatic logic [1:0] seg_count(input logic [3:0] corner);
      case (corner)
         4'd0, 4'd15: seg_count = 2'd0;
         4'd5, 4'd10: seg_count = 2'd2;
         default:     seg_count = 2'd1;
      endcase
   endfunction

   // endpoint offsets {x0, y0, x1, y1}, each stored as offset + 2
   function automatic logic [7:0] seg_ends(input logic [3:0] corner, input logic k);
      case (corner)
         4'd1:    seg_ends = {2'd1, 2'd2, 2'd2, 2'd1};
         4'd2:    seg_ends = {2'd1, 2'd2, 2'd0, 2'd1};
         4'd3:    seg_ends = {2'd2, 2'd1, 2'd0, 2'd1};
         4'd4:    seg_ends = {2'd0, 2'd1, 2'd1, 2'd0};
         4'd5:    seg_ends = k ? {2'd2, 2'd1, 2'd1, 2'd0} : {2'd1, 2'd2, 2'd0, 2'd1};
         4'd6:    seg_ends = {2'd1, 2'd2, 2'd1, 2'd0};
         4'd7:    seg_ends = {2'd2, 2'd1, 2'd1, 2'd0};
         4'd8:    seg_ends = {2'd2, 2'd1, 2'd1, 2'd0};
         4'd9:    seg_ends = {2'd1, 2'd2, 2'd1, 2'd0};
         4'd10:   seg_ends = k ? {2'd0, 2'd1, 2'd1, 2'd0} : {2'd1, 2'd2, 2'd2, 2'd1};
         4'd11:   seg_ends = {2'd0, 2'd1, 2'd1, 2'd0};
         4'd12:   seg_ends = {2'd0, 2'd1, 2'd2, 2'd1};
         4'd13:   seg_ends = {2'd1, 2'd2, 2'd0, 2'd1};
         4'd14:   seg_ends = {2'd1, 2'd2, 2'd2, 2'd1};
         default: seg_ends = '0;
      endcase
   endfunction

endpackage

FILE: hw/rtl/mscont_ram.sv
module mscont_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mscont_front.sv
module mscont_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mscont_pkg::cfg_type                   cfg,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mscont_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                  req_frame_start,
   output logic                                  push,
   output mscont_pkg::seg_item_type              push_item,
   input  logic                                  push_ready
);

   localparam int W_W  = mscont_pkg::W_W;
   localparam int H_W  = mscont_pkg::H_W;
   localparam int XI_W = mscont_pkg::XI_W;
   localparam int YI_W = mscont_pkg::YI_W;

   logic [W_W-1:0]  w_eff;
   logic [H_W-1:0]  h_eff;
   logic            accept;
   logic [W_W-1:0]  col_pre, x_cur;
   logic [YI_W-1:0] row_pre, y_cur;
   logic            x_lt_w, y_last, b_cur;

   logic [W_W-1:0]  col_ff, col_in;
   logic [YI_W-1:0] row_ff, row_in;
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_b_ff, s1_b_in;
   logic [W_W-1:0]  s1_x_ff, s1_x_in;
   logic [YI_W-1:0] s1_y_ff, s1_y_in;
   logic            s1_wr_ff, s1_wr_in;
   logic            s1_cell_ff, s1_cell_in;
   logic            byp_hit_ff, byp_hit_in;
   logic            byp_bit_ff, byp_bit_in;
   logic            above_ff, above_in;
   logic            left_above_ff, left_above_in;

   logic            ram_bit;
   logic            left;
   logic [3:0]      corner;
   logic            produce;
   logic            s1_adv;

   // clamp the grid size to the supported range
   always_comb begin
      if (cfg.grid_width < mscont_pkg::DIM_W'(2)) begin
         w_eff = W_W'(2);
      end else if (cfg.grid_width > mscont_pkg::MAX_WIDTH) begin
         w_eff = W_W'(mscont_pkg::MAX_WIDTH);
      end else begin
         w_eff = W_W'(cfg.grid_width);
      end
      if (cfg.grid_height < mscont_pkg::DIM_W'(2)) begin
         h_eff = H_W'(2);
      end else if (cfg.grid_height > mscont_pkg::MAX_HEIGHT) begin
         h_eff = H_W'(mscont_pkg::MAX_HEIGHT);
      end else begin
         h_eff = H_W'(cfg.grid_height);
      end
   end

   assign accept = req_valid && req_ready;

   // position of the incoming sample
   always_comb begin
      col_pre = req_frame_start ? '0 : col_ff;
      row_pre = req_frame_start ? '0 : row_ff;
      y_cur   = (H_W'(row_pre) >= h_eff) ? '0 : row_pre;
      x_cur   = (col_pre > w_eff) ? w_eff : col_pre;
      x_lt_w  = x_cur < w_eff;
      y_last  = (H_W'(y_cur) + H_W'(1)) >= h_eff;
      b_cur   = req_sample >= cfg.iso_level;
   end

   // corner code of the cell in stage 1
   assign left    = byp_hit_ff ? byp_bit_ff : ram_bit;
   assign corner  = {above_ff, left_above_ff, left, s1_b_ff};
   assign produce = s1_cell_ff && (mscont_pkg::seg_count(corner) != 2'd0);
   assign s1_adv  = s1_valid_ff && (!produce || push_ready);
   assign push    = s1_valid_ff && produce && push_ready;
   assign req_ready = !s1_valid_ff || s1_adv;

   assign push_item.corner = corner;
   assign push_item.x      = XI_W'(s1_x_ff);
   assign push_item.y      = s1_y_ff;

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      s1_valid_in   = s1_valid_ff;
      s1_b_in       = s1_b_ff;
      s1_x_in       = s1_x_ff;
      s1_y_in       = s1_y_ff;
      s1_wr_in      = s1_wr_ff;
      s1_cell_in    = s1_cell_ff;
      byp_hit_in    = byp_hit_ff;
      byp_bit_in    = byp_bit_ff;
      above_in      = above_ff;
      left_above_in = left_above_ff;
      if (s1_adv) begin
         s1_valid_in   = 1'b0;
         above_in      = s1_b_ff;
         left_above_in = left;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_b_in     = b_cur;
         s1_x_in     = x_cur;
         s1_y_in     = y_cur;
         s1_wr_in    = x_lt_w;
         s1_cell_in  = (x_cur != '0) && (y_cur != '0) && x_lt_w;
         // forward a column bit written on this same edge
         byp_hit_in  = s1_adv && s1_wr_ff && (s1_y_ff == y_cur);
         byp_bit_in  = s1_b_ff;
         if (y_last) begin
            row_in = '0;
            col_in = x_lt_w ? x_cur + W_W'(1) : x_cur;
         end else begin
            row_in = y_cur + YI_W'(1);
            col_in = x_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         above_ff      <= 1'b0;
         left_above_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         above_ff      <= above_in;
         left_above_ff <= left_above_in;
      end
      s1_b_ff    <= s1_b_in;
      s1_x_ff    <= s1_x_in;
      s1_y_ff    <= s1_y_in;
      s1_wr_ff   <= s1_wr_in;
      s1_cell_ff <= s1_cell_in;
      byp_hit_ff <= byp_hit_in;
      byp_bit_ff <= byp_bit_in;
   end

   mscont_ram #(
      .WIDTH (1),
      .DEPTH (mscont_pkg::MAX_HEIGHT)
   ) u_column_store (
      .clock   (clock),
      .wr_en   (s1_adv && s1_wr_ff),
      .wr_addr (s1_y_ff),
      .wr_data (s1_b_ff),
      .rd_en   (accept),
      .rd_addr (y_cur),
      .rd_data (ram_bit)
   );

endmodule

FILE: hw/rtl/mscont_fifo.sv
module mscont_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mscont_pkg::seg_item_type push_item,
   output logic                     push_ready,
   input  logic                     pop,
   output logic                     head_valid,
   output mscont_pkg::seg_item_type head
);

   localparam int AW = mscont_pkg::FIFO_AW;

   mscont_pkg::seg_item_type mem_ff [mscont_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   assign push_ready = count_ff != (AW+1)'(mscont_pkg::FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/mscont_back.sv
module mscont_back (
   input  logic                               clock,
   input  logic                               reset,
   input  mscont_pkg::cfg_type                cfg,
   input  logic                               head_valid,
   input  mscont_pkg::seg_item_type           head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mscont_pkg::SEG_W-1:0]       rsp_seg_x0,
   output logic [mscont_pkg::SEG_W-1:0]       rsp_seg_y0,
   output logic [mscont_pkg::SEG_W-1:0]       rsp_seg_x1,
   output logic [mscont_pkg::SEG_W-1:0]       rsp_seg_y1,
   output logic [mscont_pkg::COLOR_W-1:0]     rsp_seg_color,
   output logic                               rsp_last_segment
);

   localparam int SEG_W = mscont_pkg::SEG_W;
   localparam int BX_W  = mscont_pkg::XI_W + 1;
   localparam int BY_W  = mscont_pkg::YI_W + 1;
   localparam int PX_W  = BX_W + mscont_pkg::HALF_W;
   localparam int PY_W  = BY_W + mscont_pkg::HALF_W;

   logic                 load, last;
   logic [7:0]           ends;
   logic [BX_W-1:0]      bx0, bx1;
   logic [BY_W-1:0]      by0, by1;
   logic [PX_W-1:0]      px0, px1;
   logic [PY_W-1:0]      py0, py1;

   logic                               k_ff, k_in;
   logic                               valid_ff, valid_in;
   logic [SEG_W-1:0]                   x0_ff, y0_ff, x1_ff, y1_ff;
   logic [SEG_W-1:0]                   x0_in, y0_in, x1_in, y1_in;
   logic [mscont_pkg::COLOR_W-1:0]     color_ff, color_in;
   logic                               last_ff, last_in;

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign last = (2'(k_ff) + 2'd1) == mscont_pkg::seg_count(head.corner);
   assign pop  = load && last;
   assign ends = mscont_pkg::seg_ends(head.corner, k_ff);

   // endpoint = (2*index + offset) * half cell, offset stored biased by two
   always_comb begin
      bx0 = {head.x, 1'b0} + BX_W'(ends[7:6]) - BX_W'(2);
      by0 = {head.y, 1'b0} + BY_W'(ends[5:4]) - BY_W'(2);
      bx1 = {head.x, 1'b0} + BX_W'(ends[3:2]) - BX_W'(2);
      by1 = {head.y, 1'b0} + BY_W'(ends[1:0]) - BY_W'(2);
      px0 = PX_W'(bx0) * PX_W'(cfg.half_cell_width);
      px1 = PX_W'(bx1) * PX_W'(cfg.half_cell_width);
      py0 = PY_W'(by0) * PY_W'(cfg.half_cell_height);
      py1 = PY_W'(by1) * PY_W'(cfg.half_cell_height);
   end

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff && !rsp_ready;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      color_in = color_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         k_in     = !last;
         x0_in    = SEG_W'(px0);
         y0_in    = SEG_W'(py0);
         x1_in    = SEG_W'(px1);
         y1_in    = SEG_W'(py1);
         color_in = cfg.line_color;
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_seg_x0       = x0_ff;
   assign rsp_seg_y0       = y0_ff;
   assign rsp_seg_x1       = x1_ff;
   assign rsp_seg_y1       = y1_ff;
   assign rsp_seg_color    = color_ff;
   assign rsp_last_segment = last_ff;

endmodule

FILE: hw/rtl/marching_squares_contour.sv
// Throughput: one sample word per cycle while the queue has room; the single output register of the
//   segment emitter sends one segment per cycle while rsp is ready, so a saddle cell (two segments) holds it for both.
// A four-entry queue between classifier and emitter absorbs saddles and rsp stalls.
// Reset: synchronous, active high; clears position counters, corner bits, queue and handshake
//   state and restores register defaults; the column store is not cleared (no clearing pass).
module marching_squares_contour (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mscont_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                   req_frame_start,
   // segment output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mscont_pkg::SEG_W-1:0]           rsp_seg_x0,
   output logic [mscont_pkg::SEG_W-1:0]           rsp_seg_y0,
   output logic [mscont_pkg::SEG_W-1:0]           rsp_seg_x1,
   output logic [mscont_pkg::SEG_W-1:0]           rsp_seg_y1,
   output logic [mscont_pkg::COLOR_W-1:0]         rsp_seg_color,
   output logic                                   rsp_last_segment,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mscont_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mscont_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mscont_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);

   localparam int DATA_W = mscont_pkg::CSR_DATA_W;

   mscont_pkg::cfg_type       cfg_ff, cfg_in;
   mscont_pkg::csr_index_type csr_index;
   logic                      csr_write;

   logic                      push, push_ready, pop, head_valid;
   mscont_pkg::seg_item_type  push_item, head;

   // Register file: every access completes in its access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = mscont_pkg::csr_index_type'(csr_paddr[4:2]);

   // Decode writes; addresses past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            mscont_pkg::REG_ISO_LEVEL:   cfg_in.iso_level = csr_pwdata[15:0];
            mscont_pkg::REG_GRID_WIDTH:  cfg_in.grid_width = csr_pwdata[10:0];
            mscont_pkg::REG_GRID_HEIGHT: cfg_in.grid_height = csr_pwdata[10:0];
            mscont_pkg::REG_HALF_WIDTH:  cfg_in.half_cell_width = csr_pwdata[7:0];
            mscont_pkg::REG_HALF_HEIGHT: cfg_in.half_cell_height = csr_pwdata[7:0];
            mscont_pkg::REG_LINE_COLOR:  cfg_in.line_color = csr_pwdata[23:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux: return the stored bits, zero-extended.
   always_comb begin
      case (csr_index)
         mscont_pkg::REG_ISO_LEVEL:   csr_prdata = DATA_W'(cfg_ff.iso_level[15:0]);
         mscont_pkg::REG_GRID_WIDTH:  csr_prdata = DATA_W'(cfg_ff.grid_width);
         mscont_pkg::REG_GRID_HEIGHT: csr_prdata = DATA_W'(cfg_ff.grid_height);
         mscont_pkg::REG_HALF_WIDTH:  csr_prdata = DATA_W'(cfg_ff.half_cell_width);
         mscont_pkg::REG_HALF_HEIGHT: csr_prdata = DATA_W'(cfg_ff.half_cell_height);
         mscont_pkg::REG_LINE_COLOR:  csr_prdata = DATA_W'(cfg_ff.line_color);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iso_level        <= mscont_pkg::ISO_RESET;
         cfg_ff.grid_width       <= mscont_pkg::GRID_RESET;
         cfg_ff.grid_height      <= mscont_pkg::GRID_RESET;
         cfg_ff.half_cell_width  <= mscont_pkg::HALF_RESET;
         cfg_ff.half_cell_height <= mscont_pkg::HALF_RESET;
         cfg_ff.line_color       <= mscont_pkg::COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: track the grid position, threshold each sample, read the previous
   // column's bit from the column store and build the 4-bit corner code.
   // Drop cells that draw nothing; push the rest into the queue.
   mscont_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .push            (push),
      .push_item       (push_item),
      .push_ready      (push_ready)
   );

   // Queue: decouple classification from segment emission.
   mscont_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back: look up the segment table, scale endpoints by the half-cell size
   // and emit one segment word per cycle while rsp is ready; pop after the last one of a cell.
   mscont_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_x0       (rsp_seg_x0),
      .rsp_seg_y0       (rsp_seg_y0),
      .rsp_seg_x1       (rsp_seg_x1),
      .rsp_seg_y1       (rsp_seg_y1),
      .rsp_seg_color    (rsp_seg_color),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

FILE: hw/rtl/mscont_checker.sv
`include "assert_macros.svh"

module mscont_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mscont_pkg::SEG_W-1:0]        rsp_seg_x0,
   input logic [mscont_pkg::SEG_W-1:0]        rsp_seg_y0,
   input logic [mscont_pkg::SEG_W-1:0]        rsp_seg_x1,
   input logic [mscont_pkg::SEG_W-1:0]        rsp_seg_y1,
   input logic [mscont_pkg::COLOR_W-1:0]      rsp_seg_color,
   input logic                                rsp_last_segment
);

   // a stalled segment word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seg_x0) && $stable(rsp_seg_y0) && $stable(rsp_seg_x1) && $stable(rsp_seg_y1) && $stable(rsp_seg_color) && $stable(rsp_last_segment))

   // the second segment of a saddle follows right after the first
   `ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last_segment, rsp_valid)

   // reset empties the output register
   `ASSERT_IMPLIES(a_reset_no_rsp, clock, 1'b0, $past(reset), !rsp_valid)

   // reset leaves the input side open
   `ASSERT_IMPLIES(a_reset_ready, clock, 1'b0, $past(reset), req_ready)

endmodule

bind marching_squares_contour mscont_checker u_mscont_checker (.*);
